// ===== rtl/mtbr_pkg.sv =====
// Shared constants, sequencer state type and tempering function for the
// bounded Mersenne Twister generator. No dependencies.
package mtbr_pkg;

    localparam int STATE_WORDS   = 624;
    localparam int TWIST_OFFSET  = 397;
    localparam int MAX_RUN_DEF   = 64;
    localparam int TRY_LIMIT     = 1024;
    localparam int ADDR_W        = 10;
    localparam int TRY_W         = 11;

    localparam logic [31:0] DEFAULT_SEED = 32'd4357;
    localparam logic [31:0] CEIL_RESET   = 32'd2147483647;
    localparam logic [12:0] SEED_MULT    = 13'd6069;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908B0DF;
    localparam logic [31:0] TEMPER_B     = 32'h9D2C5680;
    localparam logic [31:0] TEMPER_C     = 32'hEFC60000;

    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(STATE_WORDS - 1);
    localparam logic [ADDR_W-1:0] END_POS   = ADDR_W'(STATE_WORDS);
    localparam logic [ADDR_W-1:0] RESET_POS = ADDR_W'(STATE_WORDS + 1);

    localparam logic CFG_SEED = 1'b0;
    localparam logic CFG_CEIL = 1'b1;
    localparam logic CMD_RESEED = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_THRESH,
        ST_FETCH,
        ST_TW_K,
        ST_TW_N,
        ST_TW_F,
        ST_TW_W,
        ST_RD,
        ST_CHECK,
        ST_REDUCE,
        ST_OUT
    } t_state;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ===== rtl/mt19937_bounded_random.sv =====
// Bounded random generator: 624-word Mersenne Twister state in one RAM,
// a small sequencer, and a shared iterative remainder unit (mtbr_divider).
// A draw first sets the threshold in the divider (none for a zero modulus), then for
// each word tried fetches, reads the RAM and tempers/compares, then reduces the accepted
// word in the divider (skipped for a zero modulus) and transfers it. Every 624 words the
// state is twisted word by word; a first draw after reset seeds first. One item at a time.
module mt19937_bounded_random
    import mtbr_pkg::*;
#(
    parameter int MAX_RUN = MAX_RUN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [31:0] i_modulus,
    input  logic [6:0]  i_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_value,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam logic [6:0] RUN_MAX = 7'(MAX_RUN);

    t_state r_state, n_state;

    logic [31:0] mem [STATE_WORDS];
    logic [31:0] r_mem_q;
    logic [ADDR_W-1:0] rd_addr;
    logic        wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0] wr_data;

    logic [31:0] r_seed_value, r_ceiling;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [31:0] r_seed_word, n_seed_word;
    logic        r_seed_twist, n_seed_twist;
    logic [31:0] r_modulus, n_modulus;
    logic [6:0]  r_count, n_count;
    logic [6:0]  r_num, n_num;
    logic [TRY_W-1:0] r_tries, n_tries;
    logic [31:0] r_allowed, n_allowed;
    logic [31:0] r_value, n_value;
    logic        r_hi, n_hi;
    logic [30:0] r_lo, n_lo;

    logic        div_start, div_done;
    logic [31:0] div_dividend, div_rem;
    logic [44:0] seed_prod;
    logic [ADDR_W-1:0] nxt_idx, far_idx;
    logic [ADDR_W:0]   far_sum;
    logic [31:0] y_word, tw_word;
    logic [6:0]  cnt_sat;

    mtbr_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (r_modulus),
        .o_done      (div_done),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_mem_q <= mem[rd_addr];
    end

    always_comb begin
        seed_prod = r_seed_word * SEED_MULT;
        nxt_idx   = (r_idx == LAST_WORD) ? '0 : r_idx + 1'b1;
        far_sum   = {1'b0, r_idx} + (ADDR_W + 1)'(TWIST_OFFSET);
        far_idx   = (far_sum >= (ADDR_W + 1)'(STATE_WORDS))
                    ? ADDR_W'(far_sum - (ADDR_W + 1)'(STATE_WORDS)) : far_sum[ADDR_W-1:0];
        y_word    = {r_hi, r_lo};
        tw_word   = r_mem_q ^ (y_word >> 1) ^ (y_word[0] ? TWIST_MATRIX : 32'd0);
        cnt_sat   = (i_count > RUN_MAX) ? RUN_MAX : i_count;
    end

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_idx        = r_idx;
        n_seed_word  = r_seed_word;
        n_seed_twist = r_seed_twist;
        n_modulus    = r_modulus;
        n_count      = r_count;
        n_num        = r_num;
        n_tries      = r_tries;
        n_allowed    = r_allowed;
        n_value      = r_value;
        n_hi         = r_hi;
        n_lo         = r_lo;
        rd_addr      = r_idx;
        wr_en        = 1'b0;
        wr_addr      = r_idx;
        wr_data      = r_seed_word;
        div_start    = 1'b0;
        div_dividend = r_ceiling;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_modulus = i_modulus;
                    n_count   = cnt_sat;
                    n_num     = '0;
                    n_tries   = '0;
                    if (i_command == CMD_RESEED) begin
                        n_seed_word  = r_seed_value;
                        n_idx        = '0;
                        n_seed_twist = 1'b0;
                        n_state      = ST_SEED;
                    end else if (cnt_sat != '0) begin
                        if (i_modulus != '0) begin
                            n_state = ST_THRESH;
                        end else begin
                            n_allowed = r_ceiling;
                            n_state   = ST_FETCH;
                        end
                    end
                end
            end
            ST_SEED: begin
                wr_en       = 1'b1;
                n_seed_word = seed_prod[31:0];
                n_idx       = nxt_idx;
                if (r_idx == LAST_WORD) begin
                    n_pos   = END_POS;
                    n_state = r_seed_twist ? ST_TW_K : ST_IDLE;
                end
            end
            ST_THRESH: begin
                // launch once on entry, then wait for the divider's done
                div_start = (r_tries == '0);
                n_tries   = 11'd1;
                if (div_done) begin
                    n_allowed = r_ceiling - div_rem;
                    n_tries   = '0;
                    n_state   = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_idx = '0;
                if (r_pos > END_POS) begin
                    n_seed_word  = DEFAULT_SEED;
                    n_seed_twist = 1'b1;
                    n_state      = ST_SEED;
                end else if (r_pos == END_POS) begin
                    n_state = ST_TW_K;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_TW_K: begin
                rd_addr = r_idx;
                n_state = ST_TW_N;
            end
            ST_TW_N: begin
                rd_addr = nxt_idx;
                n_hi    = r_mem_q[31];
                n_state = ST_TW_F;
            end
            ST_TW_F: begin
                rd_addr = far_idx;
                n_lo    = r_mem_q[30:0];
                n_state = ST_TW_W;
            end
            ST_TW_W: begin
                wr_en   = 1'b1;
                wr_data = tw_word;
                n_idx   = nxt_idx;
                if (r_idx == LAST_WORD) begin
                    n_pos   = '0;
                    n_state = ST_RD;
                end else begin
                    n_state = ST_TW_K;
                end
            end
            ST_RD: begin
                rd_addr = r_pos;
                n_pos   = r_pos + 1'b1;
                n_tries = r_tries + 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_value = temper(r_mem_q);
                if (temper(r_mem_q) > r_allowed && r_tries < TRY_W'(TRY_LIMIT)) begin
                    n_state = ST_FETCH;
                end else if (r_modulus != '0) begin
                    div_start    = 1'b1;
                    div_dividend = temper(r_mem_q);
                    n_state      = ST_REDUCE;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_REDUCE: begin
                if (div_done) begin
                    n_value = div_rem;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_num   = r_num + 1'b1;
                    n_tries = '0;
                    n_state = (r_num + 1'b1 == r_count) ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pos        <= RESET_POS;
            r_seed_value <= DEFAULT_SEED;
            r_ceiling    <= CEIL_RESET;
            r_tries      <= '0;
            r_num        <= '0;
            r_count      <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_tries <= n_tries;
            r_num   <= n_num;
            r_count <= n_count;
            if (i_cfg_we && i_cfg_index == CFG_SEED) begin
                r_seed_value <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_CEIL) begin
                r_ceiling <= i_cfg_data;
            end
        end
        r_idx        <= n_idx;
        r_seed_word  <= n_seed_word;
        r_seed_twist <= n_seed_twist;
        r_modulus    <= n_modulus;
        r_allowed    <= n_allowed;
        r_value      <= n_value;
        r_hi         <= n_hi;
        r_lo         <= n_lo;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign o_value = r_value;
    assign o_last  = (r_num + 1'b1 == r_count);

    a_run_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_num < r_count && r_count <= RUN_MAX))
        else $error("result index outside run");

    a_tries_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tries <= TRY_W'(TRY_LIMIT))
        else $error("retry count past limit");

    a_value_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_modulus != '0) |-> (o_value < r_modulus))
        else $error("value not below modulus");

    a_read_pos_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> (r_pos < END_POS))
        else $error("read past end of state");

endmodule

// ===== rtl/mtbr_divider.sv =====
// Iterative 32-bit remainder unit, one quotient bit per cycle.
// Depends on mtbr_pkg for nothing but house consistency of style.
module mtbr_divider
    import mtbr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_remainder
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_num, n_num;
    logic [31:0] r_div, n_div;
    logic [32:0] trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_num  = r_num;
        n_div  = r_div;
        trial  = {r_rem, r_num[31]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_num  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            // restoring step: shift in next dividend bit, subtract if it fits
            if (trial >= {1'b0, r_div}) begin
                n_rem = 32'(trial - {1'b0, r_div});
            end else begin
                n_rem = trial[31:0];
            end
            n_num = r_num << 1;
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_num <= n_num;
        r_div <= n_div;
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_remainder < r_div))
        else $error("remainder not below divisor");

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy)
        else $error("done while still busy");

endmodule

// ===== dv/mt19937_bounded_random_test.sv =====
// Self-checking test for mt19937_bounded_random: drives reseed and draw
// requests, predicts every bounded number, and compares. Depends on mtbr_pkg.
module mt19937_bounded_random_test
    import mtbr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 30_000_000;
    localparam int  SETTLE_CYCLES = 700;
    localparam logic CMD_DRAW = 1'b1;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } draw_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_command = CMD_DRAW;
    logic [31:0] i_modulus = '0;
    logic [6:0]  i_count = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_value;
    logic        o_last;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_SEED;
    logic [31:0] i_cfg_data = '0;

    mt19937_bounded_random DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] mt_words [STATE_WORDS];
    int unsigned mt_pos;
    logic [31:0] seed_reg;
    logic [31:0] ceil_reg;
    draw_t       expected_draws [$];

    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned burst_left = 0;
    int unsigned stall_mode = 0;
    bit          sender_steady = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic void seed_words(input logic [31:0] s);
        mt_words[0] = s;
        for (int i = 1; i < STATE_WORDS; i++)
            mt_words[i] = 32'(mt_words[i-1] * 32'd6069);
        mt_pos = STATE_WORDS;
    endfunction

    function automatic void twist_words();
        int unsigned nk, fk;
        logic [31:0] y;
        for (int k = 0; k < STATE_WORDS; k++) begin
            nk = (k + 1) % STATE_WORDS;
            fk = (k + TWIST_OFFSET) % STATE_WORDS;
            y = {mt_words[k][31], mt_words[nk][30:0]};
            mt_words[k] = mt_words[fk] ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'd0);
        end
        mt_pos = 0;
    endfunction

    function automatic logic [31:0] next_tempered();
        logic [31:0] y;
        if (mt_pos >= STATE_WORDS) begin
            if (mt_pos > STATE_WORDS)
                seed_words(DEFAULT_SEED);
            twist_words();
        end
        y = mt_words[mt_pos];
        mt_pos++;
        y ^= y >> 11;
        y ^= (y << 7) & TEMPER_B;
        y ^= (y << 15) & TEMPER_C;
        y ^= y >> 18;
        return y;
    endfunction

    function automatic void predict_request(input logic cmd, input logic [31:0] modulus,
                                            input logic [6:0] count);
        int unsigned runs, tries;
        logic [31:0] allowed, w;
        draw_t d;
        if (cmd == CMD_RESEED) begin
            seed_words(seed_reg);
            return;
        end
        runs = (count > MAX_RUN_DEF) ? MAX_RUN_DEF : count;
        allowed = (modulus != 0) ? ceil_reg - (ceil_reg % modulus) : ceil_reg;
        for (int n = 0; n < runs; n++) begin
            tries = 0;
            do begin
                w = next_tempered();
                tries++;
            end while (w > allowed && tries < TRY_LIMIT);
            d.value = (modulus != 0) ? w % modulus : w;
            d.last = (n + 1 == runs);
            expected_draws.push_back(d);
        end
    endfunction

    always @(posedge i_clk) begin
        draw_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("mt19937_bounded_random_test: errors");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_draws.size() == 0) begin
                report_mismatch("unexpected transfer", o_value, 32'd0);
            end else begin
                want = expected_draws.pop_front();
                if (o_value !== want.value) report_mismatch("value", o_value, want.value);
                if (o_last !== want.last) report_mismatch("last", 32'(o_last), 32'(want.last));
            end
        end
    end

    // receiver back-pressure: mode changes now and then
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 9) < 3);
            2: i_stall <= ($urandom_range(0, 9) < 8);
            default: i_stall <= (cycles[3:0] < 4'd5);
        endcase
    end

    task automatic send_request(input logic cmd, input logic [31:0] modulus,
                                input logic [6:0] count);
        int unsigned gap;
        if (!sender_steady && burst_left == 0) begin
            gap = $urandom_range(0, 20);
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_command <= cmd;
        i_modulus <= modulus;
        i_count <= count;
        do @(posedge i_clk); while (o_stall);
        predict_request(cmd, modulus, count);
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // hold until all draws are back, then let a reseed finish
    task automatic drain();
        wait (expected_draws.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_SEED) seed_reg = data;
        else ceil_reg = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_default_seed();
        send_request(CMD_DRAW, 32'd0, 7'd1);
        send_request(CMD_DRAW, 32'd1, 7'd1);
        send_request(CMD_DRAW, 32'd0, 7'd0);
        send_request(CMD_DRAW, 32'hFFFF_FFFF, 7'd3);
        send_request(CMD_DRAW, 32'd1000, 7'd127);
        send_request(CMD_DRAW, 32'd7, 7'd64);
        send_request(CMD_DRAW, 32'h7FFF_FFFF, 7'd65);
    endtask

    task automatic test_reseed();
        drain();
        write_reg(CFG_SEED, 32'd0);
        send_request(CMD_RESEED, 32'hFFFF_FFFF, 7'h7F);
        send_request(CMD_DRAW, 32'd10, 7'd5);
        drain();
        write_reg(CFG_SEED, 32'hFFFF_FFFF);
        send_request(CMD_RESEED, 32'd0, 7'd0);
        send_request(CMD_RESEED, 32'd0, 7'd0);
        send_request(CMD_DRAW, 32'h5555_5555, 7'd8);
    endtask

    task automatic test_ceiling();
        drain();
        write_reg(CFG_CEIL, 32'd1);
        send_request(CMD_DRAW, 32'd2, 7'd2);
        send_request(CMD_DRAW, 32'd1, 7'd2);
        drain();
        write_reg(CFG_CEIL, 32'hFFFF_FFFF);
        send_request(CMD_DRAW, 32'd0, 7'd4);
        send_request(CMD_DRAW, 32'h8000_0001, 7'd4);
        send_request(CMD_DRAW, 32'hFFFF_FFFF, 7'd2);
    endtask

    task automatic send_random(input int unsigned items);
        logic        cmd;
        logic [31:0] modulus;
        logic [6:0]  count;
        int unsigned pick;
        for (int i = 0; i < items; i++) begin
            cmd = ($urandom_range(0, 99) < 5) ? CMD_RESEED : CMD_DRAW;
            count = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(1, 12))
                                                 : 7'($urandom_range(0, 127));
            pick = $urandom_range(0, 99);
            if (pick < 5) modulus = 32'd0;
            else if (pick < 30) modulus = $urandom_range(1, 16);
            else if (pick < 97) modulus = $urandom_range(1, ceil_reg);
            else begin
                // may exceed the ceiling: every nonzero number then exhausts its tries
                modulus = $urandom;
                count = 7'd1;
            end
            send_request(cmd, modulus, count);
        end
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            write_reg(CFG_SEED, $urandom);
            case (ph)
                0: write_reg(CFG_CEIL, CEIL_RESET);
                1: write_reg(CFG_CEIL, 32'hFFFF_FFFF);
                default: write_reg(CFG_CEIL, $urandom_range(32'h4000_0000, 32'hFFFF_FFFF));
            endcase
            sender_steady = (ph == 2);
            send_random(100);
        end
        sender_steady = 1'b0;
    endtask

    initial begin
        seed_reg = DEFAULT_SEED;
        ceil_reg = CEIL_RESET;
        mt_pos = STATE_WORDS + 1;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_default_seed();
        test_reseed();
        test_ceiling();
        test_random();
        drain();
        if (errors == 0)
            $display("mt19937_bounded_random_test: clean");
        else
            $display("mt19937_bounded_random_test: errors");
        $finish;
    end

endmodule
